// File: rtl/core/tcr_pkg.sv
package tcr_pkg;

	localparam int COORD_W     = 32;
	localparam int COLOR_W     = 8;
	localparam int TEXID_W     = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_CULL_ENABLE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_IS_CCW = 2'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] w;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
		logic [COLOR_W-1:0]        alpha;
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
	} vertex_t;

	typedef struct packed {
		vertex_t [2:0]      vert;
		logic [TEXID_W-1:0] tex_id;
	} tri_t;

	typedef struct packed {
		logic cull_enable;
		logic front_is_ccw;
	} cfg_t;

endpackage

// File: rtl/core/tcr_front.sv
module tcr_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  tcr_pkg::vertex_t         in_vert,
	input  logic [tcr_pkg::TEXID_W-1:0] in_tex_id,
	output logic                     q_push,
	output tcr_pkg::tri_t            q_data,
	input  logic                     q_full
);
	import tcr_pkg::*;

	localparam logic [1:0] SLOT_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SECOND = 2'd1;
	localparam logic [1:0] SLOT_THIRD  = 2'd2;

	logic [1:0] vertex_count_q;
	logic       outside_seen_q;
	vertex_t    v1_q;
	vertex_t    v2_q;
	logic       accept;
	logic       cur_inside;

	// strict -w < c < w on each axis, at 33 bits so that -w cannot overflow
	function automatic logic vertex_inside(vertex_t vt);
		logic signed [COORD_W:0] w_e;
		logic signed [COORD_W:0] nw;
		logic signed [COORD_W:0] xe;
		logic signed [COORD_W:0] ye;
		logic signed [COORD_W:0] ze;
		w_e = (COORD_W+1)'(vt.w);
		nw  = -w_e;
		xe  = (COORD_W+1)'(vt.x);
		ye  = (COORD_W+1)'(vt.y);
		ze  = (COORD_W+1)'(vt.z);
		return (xe > nw) && (xe < w_e) && (ye > nw) && (ye < w_e) &&
			(ze > nw) && (ze < w_e);
	endfunction

	assign in_ready   = (vertex_count_q != SLOT_THIRD) || !q_full;
	assign accept     = in_valid && in_ready;
	assign cur_inside = vertex_inside(in_vert);

	assign q_push            = accept && (vertex_count_q == SLOT_THIRD) &&
		!outside_seen_q && cur_inside;
	assign q_data.vert[0]    = v1_q;
	assign q_data.vert[1]    = v2_q;
	assign q_data.vert[2]    = in_vert;
	assign q_data.tex_id     = in_tex_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= SLOT_FIRST;
			outside_seen_q <= 1'b0;
		end else if (accept) begin
			unique case (vertex_count_q)
				SLOT_SECOND: begin
					vertex_count_q <= SLOT_THIRD;
					outside_seen_q <= outside_seen_q || !cur_inside;
				end
				SLOT_THIRD: begin
					vertex_count_q <= SLOT_FIRST;
					outside_seen_q <= 1'b0;
				end
				default: begin
					vertex_count_q <= SLOT_SECOND;
					outside_seen_q <= !cur_inside;
				end
			endcase
		end
	end

	// hold the first two vertices of the triangle
	always_ff @(posedge clk) begin
		if (accept && (vertex_count_q == SLOT_SECOND))
			v2_q <= in_vert;
		if (accept && (vertex_count_q != SLOT_SECOND) && (vertex_count_q != SLOT_THIRD))
			v1_q <= in_vert;
	end

endmodule

// File: rtl/core/tcr_queue.sv
module tcr_queue #(
	parameter int DEPTH = tcr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcr_pkg::tri_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output tcr_pkg::tri_t rd_data
);
	import tcr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	tri_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == FULL_CNT;
	assign empty   = count_q == '0;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= wr_data;
	end

endmodule

// File: rtl/core/tcr_back.sv
module tcr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcr_pkg::cfg_t               cfg,
	input  logic                        empty,
	input  tcr_pkg::tri_t               head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tcr_pkg::vertex_t            out_vert,
	output logic [tcr_pkg::TEXID_W-1:0] out_tex_id,
	output logic                        last_vertex
);
	import tcr_pkg::*;

	// each cofactor term stays below 2^94 in magnitude, three of them summed below 2^96
	localparam int ACC_W = 100;
	localparam int PROD_W = 2 * COORD_W;
	localparam int COF_W = PROD_W + 1;
	localparam logic [2:0] ACC_FIRST  = 3'd3;
	localparam logic [2:0] ACC_LAST   = 3'd5;
	localparam logic [2:0] CALC_LAST  = 3'd6;
	localparam logic [1:0] BEAT_LAST  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                    state_q;
	logic [2:0]                cnt_q;
	logic [1:0]                beat_q;
	logic signed [PROD_W-1:0]  p_s1;
	logic signed [PROD_W-1:0]  q_s1;
	logic signed [COORD_W-1:0] m_s1;
	logic signed [COF_W-1:0]   cof_s2;
	logic signed [COORD_W-1:0] m_s2;
	logic signed [COF_W-1:0]   lo_s3;
	logic signed [COF_W-1:0]   hi_s3;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   hi_ext;
	logic signed [ACC_W-1:0]   lo_ext;
	logic signed [COORD_W-1:0] op_a;
	logic signed [COORD_W-1:0] op_b;
	logic signed [COORD_W-1:0] op_c;
	logic signed [COORD_W-1:0] op_e;
	logic signed [COORD_W-1:0] op_m;
	logic                      acc_en;
	logic                      acc_neg;
	logic                      acc_zero;
	logic                      keep;
	logic                      calc_done;
	logic                      emit_load;
	logic                      out_valid_q;
	vertex_t                   out_vert_q;
	logic [TEXID_W-1:0]        out_tex_id_q;
	logic                      last_vertex_q;

	// (v2-v1)x(v3-v1).v2 equals det[v1;v2;v3]: expand along the first row,
	// one cofactor per issue step
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin
				op_a = head.vert[1].y;
				op_b = head.vert[2].z;
				op_c = head.vert[1].z;
				op_e = head.vert[2].y;
				op_m = head.vert[0].x;
			end
			2'd1: begin
				op_a = head.vert[1].z;
				op_b = head.vert[2].x;
				op_c = head.vert[1].x;
				op_e = head.vert[2].z;
				op_m = head.vert[0].y;
			end
			default: begin
				op_a = head.vert[1].x;
				op_b = head.vert[2].y;
				op_c = head.vert[1].y;
				op_e = head.vert[2].x;
				op_m = head.vert[0].z;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1   <= op_a * op_b;
		q_s1   <= op_c * op_e;
		m_s1   <= op_m;
		cof_s2 <= COF_W'(p_s1) - COF_W'(q_s1);
		m_s2   <= m_s1;
		lo_s3  <= $signed({1'b0, cof_s2[COORD_W-1:0]}) * m_s2;
		hi_s3  <= $signed(cof_s2[COF_W-1:COORD_W]) * m_s2;
	end

	assign hi_ext    = ACC_W'(hi_s3);
	assign lo_ext    = ACC_W'(lo_s3);
	assign acc_en    = (state_q == ST_CALC) && (cnt_q >= ACC_FIRST) && (cnt_q <= ACC_LAST);
	assign acc_neg   = acc_q[ACC_W-1];
	assign acc_zero  = acc_q == '0;
	assign keep      = cfg.front_is_ccw ? (!acc_neg && !acc_zero) : acc_neg;
	assign calc_done = (state_q == ST_CALC) && (cnt_q == CALC_LAST);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign pop       = (calc_done && !keep) || (emit_load && (beat_q == BEAT_LAST));

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && !empty)
			acc_q <= '0;
		else if (acc_en)
			acc_q <= acc_q + (hi_ext <<< COORD_W) + lo_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			beat_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					beat_q <= '0;
					if (!empty)
						state_q <= cfg.cull_enable ? ST_CALC : ST_EMIT;
				end
				ST_CALC: begin
					if (calc_done)
						state_q <= keep ? ST_EMIT : ST_IDLE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (beat_q == BEAT_LAST)
							state_q <= ST_IDLE;
						else
							beat_q <= beat_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_vert_q    <= head.vert[beat_q];
			out_tex_id_q  <= head.tex_id;
			last_vertex_q <= beat_q == BEAT_LAST;
		end
	end

	// acc_q is only read once the issue steps have drained
	assign out_valid   = out_valid_q;
	assign out_vert    = out_vert_q;
	assign out_tex_id  = out_tex_id_q;
	assign last_vertex = last_vertex_q;

endmodule

// File: rtl/core/triangle_clip_reject_and_backface_cull.sv
// Triangle trivial reject and back-face cull.
// Input channel in_valid/in_ready carries one clip-space vertex per
// transaction (position, colour, texture coordinates, texture id); each
// three vertices form a triangle. A triangle with any vertex outside
// -w < c < w on x, y or z is dropped as its third vertex arrives.
// Output channel out_valid/out_ready carries the three vertices of each kept
// triangle, the texture id of the third vertex on all three, last_vertex on
// the third. Configuration (cfg_wr_en, cfg_index, cfg_data) sets cull_enable
// and front_is_ccw; write it only while the block is idle.
// A kept triangle goes from the queue to the back, which loads its vertices
// into the output register, with culling on only after forming the facing
// sign: the determinant of the three positions, in a 4-stage multiplier
// pipeline over 3 issue steps. The front takes a vertex every cycle unless
// a third vertex finds the queue full; the back finishes one triangle before
// the next, and the queue between them sets how far the front may run ahead.
// Reset clears the vertex count, the queue and the output valid, and
// sets cull_enable 0, front_is_ccw 1. A stalled receiver holds the output
// register; the queue fills and then in_ready drops on third vertices.
module triangle_clip_reject_and_backface_cull #(
	parameter int QUEUE_DEPTH = tcr_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tcr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic                                cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tcr_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [tcr_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [tcr_pkg::COORD_W-1:0]  pos_z,
	input  logic signed [tcr_pkg::COORD_W-1:0]  pos_w,
	input  logic [tcr_pkg::COLOR_W-1:0]         red,
	input  logic [tcr_pkg::COLOR_W-1:0]         green,
	input  logic [tcr_pkg::COLOR_W-1:0]         blue,
	input  logic [tcr_pkg::COLOR_W-1:0]         alpha,
	input  logic signed [tcr_pkg::COORD_W-1:0]  tex_u,
	input  logic signed [tcr_pkg::COORD_W-1:0]  tex_v,
	input  logic [tcr_pkg::TEXID_W-1:0]         tex_id,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tcr_pkg::COORD_W-1:0]  out_x,
	output logic signed [tcr_pkg::COORD_W-1:0]  out_y,
	output logic signed [tcr_pkg::COORD_W-1:0]  out_z,
	output logic signed [tcr_pkg::COORD_W-1:0]  out_w,
	output logic [tcr_pkg::COLOR_W-1:0]         out_red,
	output logic [tcr_pkg::COLOR_W-1:0]         out_green,
	output logic [tcr_pkg::COLOR_W-1:0]         out_blue,
	output logic [tcr_pkg::COLOR_W-1:0]         out_alpha,
	output logic signed [tcr_pkg::COORD_W-1:0]  out_u,
	output logic signed [tcr_pkg::COORD_W-1:0]  out_v,
	output logic [tcr_pkg::TEXID_W-1:0]         out_tex_id,
	output logic                                last_vertex
);
	import tcr_pkg::*;

	cfg_t    cfg_q;
	vertex_t in_vert;
	vertex_t out_vert;
	tri_t    q_wr_data;
	tri_t    q_rd_data;
	logic    q_push;
	logic    q_pop;
	logic    q_full;
	logic    q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cull_enable  <= 1'b0;
			cfg_q.front_is_ccw <= 1'b1;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_CULL_ENABLE)
				cfg_q.cull_enable <= cfg_data;
			else if (cfg_index == CFG_FRONT_IS_CCW)
				cfg_q.front_is_ccw <= cfg_data;
		end
	end

	assign in_vert.x     = pos_x;
	assign in_vert.y     = pos_y;
	assign in_vert.z     = pos_z;
	assign in_vert.w     = pos_w;
	assign in_vert.red   = red;
	assign in_vert.green = green;
	assign in_vert.blue  = blue;
	assign in_vert.alpha = alpha;
	assign in_vert.u     = tex_u;
	assign in_vert.v     = tex_v;

	tcr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_vert       (in_vert),
		.in_tex_id     (tex_id),
		.q_push        (q_push),
		.q_data        (q_wr_data),
		.q_full        (q_full)
	);

	tcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (q_rd_data)
	);

	tcr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.empty          (q_empty),
		.head           (q_rd_data),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_vert       (out_vert),
		.out_tex_id     (out_tex_id),
		.last_vertex    (last_vertex)
	);

	assign out_x     = out_vert.x;
	assign out_y     = out_vert.y;
	assign out_z     = out_vert.z;
	assign out_w     = out_vert.w;
	assign out_red   = out_vert.red;
	assign out_green = out_vert.green;
	assign out_blue  = out_vert.blue;
	assign out_alpha = out_vert.alpha;
	assign out_u     = out_vert.u;
	assign out_v     = out_vert.v;

endmodule
